FILE: hdl/phbp_pkg.sv
// ----------------------------------------------------------------------------
// Packet header bit packer package
// Shared widths, operation codes and the command and status structs that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package phbp_pkg;

  localparam int unsigned FuncW     = 3;
  localparam int unsigned BitCountW = 4;
  localparam int unsigned BitValueW = 15;
  localparam int unsigned ZeroPlnW  = 5;
  localparam int unsigned PassCntW  = 8;
  localparam int unsigned SegLenW   = 15;
  localparam int unsigned ByteW     = 8;

  // Operation codes carried in the func field.
  localparam logic [FuncW-1:0] FUNC_RAW         = 3'd0;
  localparam logic [FuncW-1:0] FUNC_ZERO_PLANES = 3'd1;
  localparam logic [FuncW-1:0] FUNC_PASS_CODE   = 3'd2;
  localparam logic [FuncW-1:0] FUNC_LBLOCK      = 3'd3;
  localparam logic [FuncW-1:0] FUNC_FLUSH       = 3'd4;

  // A byte of all ones forces a stuffed zero at the top of the next byte.
  localparam logic [ByteW-1:0] STUFF_BYTE = 8'hff;

  typedef struct packed {
    logic load;  // take the accepted request into the datapath
    logic step;  // pack one chunk of bits, or perform the flush
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;  // the output register can take a byte this cycle
    logic finish;    // the current step completes the request
  } dp_status_t;

endpackage

FILE: hdl/phbp_in_if.sv
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one header field request.
// ----------------------------------------------------------------------------
interface phbp_in_if;
  import phbp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [FuncW-1:0]     func;
  logic [BitCountW-1:0] bit_count;
  logic [BitValueW-1:0] bit_value;
  logic [ZeroPlnW-1:0]  zero_planes;
  logic [PassCntW-1:0]  pass_count;
  logic [SegLenW-1:0]   seg_length;

  modport source (
    output valid, func, bit_count, bit_value, zero_planes, pass_count, seg_length,
    input  ready
  );

  modport sink (
    input  valid, func, bit_count, bit_value, zero_planes, pass_count, seg_length,
    output ready
  );

endinterface

FILE: hdl/phbp_out_if.sv
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying one packed header byte.
// ----------------------------------------------------------------------------
interface phbp_out_if;
  import phbp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             last_of_item;

  modport source (
    output valid, out_byte, last_of_item,
    input  ready
  );

  modport sink (
    input  valid, out_byte, last_of_item,
    output ready
  );

endinterface

FILE: hdl/packet_header_bit_packer.sv
// A request is accepted only while the controller is idle, then packed one
// chunk per cycle while the output register is free; a new request is not
// taken until the last chunk of the current one is packed. Each finished byte
// is registered in the output register before it is presented.
// A stalled output register holds the packer until the byte is taken.
// Reset empties the partial byte and leaves eight free bits.
// ----------------------------------------------------------------------------
// Packet header bit packer
// Packs packet header codes MSB first into bytes with bit stuffing.
// ----------------------------------------------------------------------------
module packet_header_bit_packer (
  input  logic     clk_i,
  input  logic     rst_ni,
  phbp_in_if.sink  in_i,
  phbp_out_if.source out_o
);
  import phbp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  phbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  phbp_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .func_i        (in_i.func),
    .bit_count_i   (in_i.bit_count),
    .bit_value_i   (in_i.bit_value),
    .zero_planes_i (in_i.zero_planes),
    .pass_count_i  (in_i.pass_count),
    .seg_length_i  (in_i.seg_length),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_byte_o    (out_o.out_byte),
    .out_last_o    (out_o.last_of_item)
  );

endmodule

FILE: hdl/phbp_ctrl.sv
// ----------------------------------------------------------------------------
// Packet header bit packer controller
// Two-state sequencer: waits for a request, then steps the datapath until
// the request's bits have all been packed.
// ----------------------------------------------------------------------------
module phbp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  phbp_pkg::dp_status_t  status_i,
  output phbp_pkg::ctrl_cmd_t   cmd_o
);
  import phbp_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);
  assign cmd_o.load = in_valid_i && in_ready_o;
  assign cmd_o.step = (state_q == ST_RUN) && status_i.out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (cmd_o.step && status_i.finish) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/phbp_datapath.sv
// ----------------------------------------------------------------------------
// Packet header bit packer datapath
// Encodes a request into a left-aligned bit string and moves it into the partial
// byte one chunk per step, stuffing after an all-ones byte; a flush emits any partial byte.
// ----------------------------------------------------------------------------
module phbp_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  phbp_pkg::ctrl_cmd_t            cmd_i,
  output phbp_pkg::dp_status_t           status_o,
  input  logic [phbp_pkg::FuncW-1:0]     func_i,
  input  logic [phbp_pkg::BitCountW-1:0] bit_count_i,
  input  logic [phbp_pkg::BitValueW-1:0] bit_value_i,
  input  logic [phbp_pkg::ZeroPlnW-1:0]  zero_planes_i,
  input  logic [phbp_pkg::PassCntW-1:0]  pass_count_i,
  input  logic [phbp_pkg::SegLenW-1:0]   seg_length_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [phbp_pkg::ByteW-1:0]     out_byte_o,
  output logic                           out_last_o
);
  import phbp_pkg::*;

  // Bit string register and bookkeeping.
  logic [31:0]      sr_q, sr_d;
  logic [5:0]       rem_q, rem_d;
  logic             flush_q, flush_d;
  logic [ByteW-1:0] partial_q, partial_d;
  logic [3:0]       free_q, free_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;

  // Encoder signals.
  logic [31:0]          enc_value;
  logic [5:0]           enc_count;
  logic [BitValueW-1:0] raw_mask;
  logic [3:0]           len_log;
  logic [2:0]           pass_log;
  logic [3:0]           len_bits;
  logic [3:0]           p_plus3;
  logic [3:0]           ones_k;
  logic [3:0]           len_width;
  logic [31:0]          ones_mask;
  logic [7:0]           pc_off;

  // Step signals.
  logic [3:0]       n_take;
  logic [3:0]       free_after;
  logic [5:0]       rem_after;
  logic [ByteW-1:0] top_mask;
  logic [ByteW-1:0] chunk;
  logic [ByteW-1:0] partial_next;
  logic             byte_done;
  logic [3:0]       free_new;
  logic             emit;

  // Priority encoders for floor(log2) of the length and the pass count.
  always_comb begin
    len_log = 4'd0;
    for (int i = 1; i < SegLenW; i++) begin
      if (seg_length_i[i]) len_log = 4'(i);
    end
    pass_log = 3'd0;
    for (int i = 1; i < PassCntW; i++) begin
      if (pass_count_i[i]) pass_log = 3'(i);
    end
  end

  always_comb begin
    raw_mask  = ~({BitValueW{1'b1}} << bit_count_i);
    len_bits  = len_log + 4'd1;
    p_plus3   = {1'b0, pass_log} + 4'd3;
    if (len_bits >= p_plus3) begin
      ones_k    = len_bits - p_plus3;
      len_width = len_bits;
    end else begin
      ones_k    = 4'd0;
      len_width = p_plus3;
    end
    ones_mask = ~(32'hffff_ffff << ones_k);
    pc_off    = 8'd0;
    enc_value = 32'd0;
    enc_count = 6'd0;
    unique case (func_i)
      FUNC_RAW: begin
        enc_value = {17'd0, bit_value_i & raw_mask};
        enc_count = {2'd0, bit_count_i};
      end
      FUNC_ZERO_PLANES: begin
        enc_value = 32'd1;
        enc_count = {1'b0, zero_planes_i} + 6'd1;
      end
      FUNC_PASS_CODE: begin
        if (pass_count_i == 8'd1) begin
          enc_value = 32'd0;
          enc_count = 6'd1;
        end else if (pass_count_i == 8'd2) begin
          enc_value = 32'd2;
          enc_count = 6'd2;
        end else if (pass_count_i >= 8'd3 && pass_count_i <= 8'd5) begin
          pc_off    = pass_count_i - 8'd3;
          enc_value = 32'd12 + {24'd0, pc_off};
          enc_count = 6'd4;
        end else if (pass_count_i >= 8'd6 && pass_count_i <= 8'd36) begin
          pc_off    = pass_count_i - 8'd6;
          enc_value = {23'd0, 4'hf, pc_off[4:0]};
          enc_count = 6'd9;
        end else if (pass_count_i >= 8'd37 && pass_count_i <= 8'd164) begin
          pc_off    = pass_count_i - 8'd37;
          enc_value = {16'd0, 9'h1ff, pc_off[6:0]};
          enc_count = 6'd16;
        end
      end
      FUNC_LBLOCK: begin
        if (seg_length_i != '0 && pass_count_i != '0) begin
          // Ones of the Lblock increment, a terminating zero, then the length.
          enc_value = (ones_mask << ({1'b0, len_width} + 5'd1)) | {17'd0, seg_length_i};
          enc_count = {2'd0, ones_k} + {2'd0, len_width} + 6'd1;
        end
      end
      default: begin
        enc_value = 32'd0;
        enc_count = 6'd0;
      end
    endcase
  end

  // One step takes as many bits as fit in the partial byte.
  always_comb begin
    n_take       = (rem_q < {2'd0, free_q}) ? rem_q[3:0] : free_q;
    free_after   = free_q - n_take;
    rem_after    = rem_q - {2'd0, n_take};
    top_mask     = 8'hff << (4'd8 - n_take);
    chunk        = (sr_q[31:24] & top_mask) >> (4'd8 - free_q);
    partial_next = partial_q | chunk;
    byte_done    = !flush_q && (free_after == 4'd0);
    free_new     = (partial_next == STUFF_BYTE) ? 4'd7 : 4'd8;
    emit         = flush_q ? (free_q < 4'd8) : byte_done;
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.finish   = flush_q || (rem_after == 6'd0);

  always_comb begin
    sr_d        = sr_q;
    rem_d       = rem_q;
    flush_d     = flush_q;
    partial_d   = partial_q;
    free_d      = free_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (cmd_i.load) begin
      sr_d    = enc_value << (6'd32 - enc_count);
      rem_d   = enc_count;
      flush_d = (func_i == FUNC_FLUSH);
    end else if (cmd_i.step) begin
      if (flush_q) begin
        if (emit) begin
          partial_d = '0;
          free_d    = 4'd8;
        end
      end else begin
        sr_d  = sr_q << n_take;
        rem_d = rem_after;
        if (byte_done) begin
          partial_d = '0;
          free_d    = free_new;
        end else begin
          partial_d = partial_next;
          free_d    = free_after;
        end
      end
      if (emit) begin
        out_valid_d = 1'b1;
        out_byte_d  = flush_q ? partial_q : partial_next;
        // The byte is the last one unless the remaining bits fill another.
        out_last_d  = flush_q || ({2'd0, free_new} > rem_after);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      flush_q     <= 1'b0;
      partial_q   <= '0;
      free_q      <= 4'd8;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      flush_q     <= flush_d;
      partial_q   <= partial_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q       <= sr_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet header bit packer testbench
// Sends a table of header field requests, then random requests under three
// handshake idling regimes. Every byte taken from the output is checked against a
// bit-level model of the packer, stuffing and flushing included, or against the hand-written bytes of typed rows.
// ----------------------------------------------------------------------------
module testbench;
  import phbp_pkg::*;

  // Selector values that the block ignores.
  localparam logic [FuncW-1:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [FuncW-1:0] FUNC_SPARE_HI = 3'd7;
  localparam int unsigned      MaxBytes      = 8;

  typedef struct packed {
    logic [FuncW-1:0]     func;
    logic [BitCountW-1:0] bit_count;
    logic [BitValueW-1:0] bit_value;
    logic [ZeroPlnW-1:0]  zero_planes;
    logic [PassCntW-1:0]  pass_count;
    logic [SegLenW-1:0]   seg_length;
  } header_req_t;

  typedef struct packed {
    header_req_t req;
    logic        typed;        // bytes below are written out by hand
    logic [2:0]  n_typed;
    logic [31:0] typed_bytes;  // first byte in the top eight bits
  } table_row_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } hdr_byte_t;

  localparam table_row_t HeaderTable [25] = '{
    '{'{FUNC_RAW, 4'd8, 15'h00a5, 5'd0, 8'd0, 15'd0}, 1'b1, 3'd1, 32'ha500_0000},
    '{'{FUNC_RAW, 4'd8, 15'h7fff, 5'd0, 8'd0, 15'd0}, 1'b1, 3'd1, 32'hff00_0000},
    '{'{FUNC_FLUSH, 4'd0, 15'd0, 5'd0, 8'd0, 15'd0}, 1'b1, 3'd1, 32'h0000_0000},
    '{'{FUNC_RAW, 4'd0, 15'h7fff, 5'd0, 8'd0, 15'd0}, 1'b1, 3'd0, 32'h0000_0000},
    '{'{FUNC_RAW, 4'd15, 15'h7fff, 5'd0, 8'd0, 15'd0}, 1'b1, 3'd2, 32'hff7f_0000},
    '{'{FUNC_ZERO_PLANES, 4'd0, 15'd0, 5'd31, 8'd0, 15'd0}, 1'b1, 3'd4, 32'h0000_0001},
    '{'{FUNC_ZERO_PLANES, 4'd0, 15'd0, 5'd0, 8'd0, 15'd0}, 1'b1, 3'd0, 32'h0000_0000},
    '{'{FUNC_FLUSH, 4'd0, 15'd0, 5'd0, 8'd0, 15'd0}, 1'b1, 3'd1, 32'h8000_0000},
    '{'{FUNC_FLUSH, 4'd0, 15'd0, 5'd0, 8'd0, 15'd0}, 1'b1, 3'd0, 32'h0000_0000},
    '{'{FUNC_PASS_CODE, 4'd0, 15'd0, 5'd0, 8'd1, 15'd0}, 1'b0, 3'd0, 32'h0000_0000},
    '{'{FUNC_PASS_CODE, 4'd0, 15'd0, 5'd0, 8'd2, 15'd0}, 1'b0, 3'd0, 32'h0000_0000},
    '{'{FUNC_PASS_CODE, 4'd0, 15'd0, 5'd0, 8'd5, 15'd0}, 1'b0, 3'd0, 32'h0000_0000},
    '{'{FUNC_PASS_CODE, 4'd0, 15'd0, 5'd0, 8'd36, 15'd0}, 1'b0, 3'd0, 32'h0000_0000},
    '{'{FUNC_PASS_CODE, 4'd0, 15'd0, 5'd0, 8'd37, 15'd0}, 1'b0, 3'd0, 32'h0000_0000},
    '{'{FUNC_PASS_CODE, 4'd0, 15'd0, 5'd0, 8'd164, 15'd0}, 1'b0, 3'd0, 32'h0000_0000},
    '{'{FUNC_PASS_CODE, 4'd0, 15'd0, 5'd0, 8'd0, 15'd0}, 1'b1, 3'd0, 32'h0000_0000},
    '{'{FUNC_PASS_CODE, 4'd0, 15'd0, 5'd0, 8'd200, 15'd0}, 1'b1, 3'd0, 32'h0000_0000},
    '{'{FUNC_LBLOCK, 4'd0, 15'd0, 5'd0, 8'd1, 15'd1}, 1'b0, 3'd0, 32'h0000_0000},
    '{'{FUNC_LBLOCK, 4'd0, 15'd0, 5'd0, 8'd1, 15'h7fff}, 1'b0, 3'd0, 32'h0000_0000},
    '{'{FUNC_LBLOCK, 4'd0, 15'd0, 5'd0, 8'd5, 15'd0}, 1'b1, 3'd0, 32'h0000_0000},
    '{'{FUNC_LBLOCK, 4'd0, 15'd0, 5'd0, 8'd0, 15'd5}, 1'b1, 3'd0, 32'h0000_0000},
    '{'{FUNC_LBLOCK, 4'd0, 15'd0, 5'd0, 8'd255, 15'h7fff}, 1'b0, 3'd0, 32'h0000_0000},
    '{'{FUNC_SPARE_LO, 4'd8, 15'h7fff, 5'd31, 8'd9, 15'd9}, 1'b1, 3'd0, 32'h0000_0000},
    '{'{FUNC_SPARE_HI, 4'd8, 15'h7fff, 5'd31, 8'd9, 15'd9}, 1'b1, 3'd0, 32'h0000_0000},
    '{'{FUNC_FLUSH, 4'd0, 15'd0, 5'd0, 8'd0, 15'd0}, 1'b0, 3'd0, 32'h0000_0000}
  };

  logic clk_i;
  logic rst_ni;

  phbp_in_if  req_if ();
  phbp_out_if byte_if ();

  packet_header_bit_packer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (byte_if)
  );

  // Model of the packer state and the bytes still owed by the block.
  logic [ByteW-1:0] acc_byte;
  logic [3:0]       acc_free;
  logic [ByteW-1:0] item_bytes [$];
  hdr_byte_t        pending_bytes [$];

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned mismatch_count;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("packet_header_bit_packer: mismatch");
    $finish;
  end

  function automatic void emit_byte(logic [ByteW-1:0] b);
    if (item_bytes.size() < MaxBytes) item_bytes.push_back(b);
  endfunction

  function automatic void append_bits(logic [31:0] value, int unsigned count);
    logic [ByteW-1:0] done;
    for (int unsigned i = count; i > 0; i--) begin
      if (acc_free == 0 || acc_free > ByteW) acc_free = 4'(ByteW);
      acc_free = acc_free - 4'd1;
      acc_byte = acc_byte | (ByteW'(value[i-1]) << acc_free);
      if (acc_free == 0) begin
        done = acc_byte;
        emit_byte(done);
        acc_byte = '0;
        // A full byte of ones leaves room for seven bits only.
        acc_free = (done == STUFF_BYTE) ? 4'd7 : 4'd8;
      end
    end
  endfunction

  function automatic int unsigned floor_log2(logic [31:0] v);
    int unsigned r;
    r = 0;
    while (v > 1) begin
      v = v >> 1;
      r++;
    end
    return r;
  endfunction

  function automatic void pack_pass_code(int unsigned n);
    if (n == 1) begin
      append_bits(0, 1);
    end else if (n == 2) begin
      append_bits(2, 2);
    end else if (n >= 3 && n <= 5) begin
      append_bits(12 + n - 3, 4);
    end else if (n >= 6 && n <= 36) begin
      append_bits(15, 4);
      append_bits(n - 6, 5);
    end else if (n >= 37 && n <= 164) begin
      append_bits(32'h1ff, 9);
      append_bits(n - 37, 7);
    end
  endfunction

  function automatic void pack_lblock(int unsigned len, int unsigned passes);
    int unsigned b;
    int unsigned p;
    int unsigned width;
    if (len == 0 || passes == 0) return;
    b = floor_log2(len) + 1;
    p = floor_log2(passes);
    if (b >= p + 3) begin
      append_bits(32'hffff, b - p - 3);
      width = b;
    end else begin
      width = p + 3;
    end
    append_bits(0, 1);
    append_bits(len, width);
  endfunction

  // Advances the model by one request and leaves its bytes in item_bytes.
  function automatic void pack_request(header_req_t r);
    item_bytes.delete();
    case (r.func)
      FUNC_RAW: begin
        append_bits(32'(r.bit_value) & ((32'd1 << r.bit_count) - 1), 32'(r.bit_count));
      end
      FUNC_ZERO_PLANES: begin
        append_bits(1, 32'(r.zero_planes) + 1);
      end
      FUNC_PASS_CODE: begin
        pack_pass_code(32'(r.pass_count));
      end
      FUNC_LBLOCK: begin
        pack_lblock(32'(r.seg_length), 32'(r.pass_count));
      end
      FUNC_FLUSH: begin
        if (acc_free < ByteW) begin
          emit_byte(acc_byte);
          acc_byte = '0;
          acc_free = 4'(ByteW);
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic header_req_t random_request();
    header_req_t r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) r.func = FUNC_RAW;
    else if (pick < 45) r.func = FUNC_ZERO_PLANES;
    else if (pick < 62) r.func = FUNC_PASS_CODE;
    else if (pick < 82) r.func = FUNC_LBLOCK;
    else if (pick < 94) r.func = FUNC_FLUSH;
    else r.func = FuncW'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
    r.bit_count   = BitCountW'($urandom_range(15));
    // Runs of ones make full bytes and so exercise the stuffing.
    r.bit_value   = ($urandom_range(3) == 0) ? '1 : BitValueW'($urandom);
    r.zero_planes = ZeroPlnW'($urandom);
    case ($urandom_range(3))
      0:       r.pass_count = PassCntW'($urandom_range(5, 1));
      1:       r.pass_count = PassCntW'($urandom_range(36, 6));
      2:       r.pass_count = PassCntW'($urandom_range(164, 37));
      default: r.pass_count = PassCntW'($urandom);
    endcase
    r.seg_length = ($urandom_range(2) == 0) ? SegLenW'($urandom_range(15, 1))
                                            : SegLenW'($urandom);
    return r;
  endfunction

  task automatic note_failure(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, what);
  endtask

  task automatic send_request(input header_req_t req, input logic typed,
                              input int unsigned n_typed, input logic [31:0] typed_bytes);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.func        <= req.func;
    req_if.bit_count   <= req.bit_count;
    req_if.bit_value   <= req.bit_value;
    req_if.zero_planes <= req.zero_planes;
    req_if.pass_count  <= req.pass_count;
    req_if.seg_length  <= req.seg_length;
    do @(posedge clk_i); while (!req_if.ready);
    pack_request(req);
    // Hand-written rows replace the model's bytes but the model still advances.
    if (typed) begin
      for (int unsigned k = 0; k < n_typed; k++) begin
        pending_bytes.push_back('{typed_bytes[31-8*k -: 8], k == n_typed - 1});
      end
    end else begin
      foreach (item_bytes[k]) begin
        pending_bytes.push_back('{item_bytes[k], k == item_bytes.size() - 1});
      end
    end
  endtask

  always @(posedge clk_i) begin
    hdr_byte_t want;
    if (rst_ni && byte_if.valid && byte_if.ready) begin
      if (pending_bytes.size() == 0) begin
        note_failure($sformatf("unexpected byte %02h last %0b",
                               byte_if.out_byte, byte_if.last_of_item));
      end else begin
        want = pending_bytes.pop_front();
        if (want.data !== byte_if.out_byte || want.last !== byte_if.last_of_item) begin
          note_failure($sformatf("byte %02h last %0b, expected byte %02h last %0b",
                                 byte_if.out_byte, byte_if.last_of_item,
                                 want.data, want.last));
        end
      end
    end
    byte_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    req_if.valid       = 1'b0;
    req_if.func        = '0;
    req_if.bit_count   = '0;
    req_if.bit_value   = '0;
    req_if.zero_planes = '0;
    req_if.pass_count  = '0;
    req_if.seg_length  = '0;
    byte_if.ready      = 1'b0;
    rst_ni             = 1'b0;
    acc_byte           = '0;
    acc_free           = 4'(ByteW);
    mismatch_count     = 0;
    tx_idle_pct        = 35;
    rx_idle_pct        = 60;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (HeaderTable[i]) begin
      send_request(HeaderTable[i].req, HeaderTable[i].typed,
                   HeaderTable[i].n_typed, HeaderTable[i].typed_bytes);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin tx_idle_pct = 35; rx_idle_pct = 60; end
        1:       begin tx_idle_pct = 60; rx_idle_pct = 35; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      repeat (102) send_request(random_request(), 1'b0, 0, 32'd0);
    end
    req_if.valid <= 1'b0;

    for (int n = 0; n < 4000 && pending_bytes.size() != 0; n++) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    foreach (pending_bytes[k]) begin
      note_failure($sformatf("byte %02h last %0b never arrived",
                             pending_bytes[k].data, pending_bytes[k].last));
    end

    if (mismatch_count == 0) begin
      $display("packet_header_bit_packer: match");
    end else begin
      $display("packet_header_bit_packer: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/phbp_pkg.sv
hdl/phbp_in_if.sv
hdl/phbp_out_if.sv
hdl/phbp_ctrl.sv
hdl/phbp_datapath.sv
hdl/packet_header_bit_packer.sv
tb/testbench.sv
